### rtl/acfp_pkg.sv
`default_nettype none

package acfp_pkg;

   // Widths of the item fields on both channels.
   localparam int unsigned RX_BYTE_W = 8;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned CAN_ID_W  = 32;
   localparam int unsigned LENGTH_W  = 4;
   localparam int unsigned PAYLOAD_W = 64;

   // Line status reported with every carriage return.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_TYPE = 2'd1,
      STATUS_BAD_LEN  = 2'd2,
      STATUS_BAD_HEX  = 2'd3
   } status_type;

   // Characters with a meaning to the parser.
   localparam logic [RX_BYTE_W-1:0] CHAR_CR      = 8'h0D;
   localparam logic [RX_BYTE_W-1:0] CHAR_EXT_LO  = 8'h78;  // x
   localparam logic [RX_BYTE_W-1:0] CHAR_EXT_UP  = 8'h58;  // X
   localparam logic [RX_BYTE_W-1:0] CHAR_STD_LO  = 8'h74;  // t
   localparam logic [RX_BYTE_W-1:0] CHAR_STD_UP  = 8'h54;  // T

   // Decoded hex digit: valid flag and nibble value.
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [RX_BYTE_W-1:0] c);
      hex_digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = 4'(c - 8'h37);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

### rtl/acfp_if.sv
`default_nettype none

// Channel that carries received characters into the parser.
interface acfp_req_if
   import acfp_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [RX_BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Channel that carries one parsed frame line out of the parser.
interface acfp_rsp_if
   import acfp_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic                 extended;
   logic [CAN_ID_W-1:0]  can_id;
   logic [LENGTH_W-1:0]  length;
   logic [PAYLOAD_W-1:0] payload;

   modport source (output valid, output status, output extended, output can_id,
                   output length, output payload, input ready);
   modport sink   (input valid, input status, input extended, input can_id,
                   input length, input payload, output ready);
endinterface

`default_nettype wire

### rtl/ascii_can_frame_parser.sv
`default_nettype none

// ASCII CAN frame line parser. Characters enter on the req_chan channel one
// item per cycle and are parsed as text lines ended by a carriage return: a
// type character (x or X for an extended frame with EXT_ID_DIGITS hex id
// digits, t or T for a standard frame with STD_ID_DIGITS digits), two hex
// length digits, then two hex digits per data byte, high nibble first. Every
// carriage return, and nothing else, produces one item on rsp_chan carrying
// the status, the extended flag, the unmasked id, the length and the data
// bytes packed with byte 0 in bits 7..0. When the status is not ok, all the
// other fields read zero. Characters after the payload are ignored. The
// block takes one character every cycle unless it stalls: a character is
// captured in an input register, and when it is processed from there a single
// per-character update of the line state writes the parse state and, on a
// carriage return, the result register, which drives rsp_chan. Input only
// stalls when a carriage return waits in the input register while the
// previous result is still held by the sink.
module ascii_can_frame_parser
   import acfp_pkg::*;
#(
   parameter int unsigned EXT_ID_DIGITS  = 8,
   parameter int unsigned STD_ID_DIGITS  = 3,
   parameter int unsigned MAX_DATA_BYTES = 8
) (
   input  wire         clock,
   input  wire         reset,
   acfp_req_if.sink    req_chan,
   acfp_rsp_if.source  rsp_chan
);

   localparam logic [4:0] EXT_DIGITS = 5'(EXT_ID_DIGITS);
   localparam logic [4:0] STD_DIGITS = 5'(STD_ID_DIGITS);
   localparam logic [4:0] LEN_DIGITS = 5'd2;
   localparam logic [7:0] MAX_LEN    = 8'(MAX_DATA_BYTES);

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_ID,
      PH_LEN,
      PH_DATA,
      PH_DONE,
      PH_ERR
   } phase_type;

   // Input register.
   logic                 in_valid_ff, in_valid_in;
   logic [RX_BYTE_W-1:0] in_byte_ff, in_byte_in;

   // Line state.
   phase_type            phase_ff, phase_in;
   logic [4:0]           digit_count_ff, digit_count_in;
   logic [CAN_ID_W-1:0]  id_acc_ff, id_acc_in;
   logic [7:0]           len_acc_ff, len_acc_in;
   logic [PAYLOAD_W-1:0] payload_acc_ff, payload_acc_in;
   logic                 extended_ff, extended_in;
   status_type           error_code_ff, error_code_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_extended_ff, rsp_extended_in;
   logic [CAN_ID_W-1:0]  rsp_can_id_ff, rsp_can_id_in;
   logic [LENGTH_W-1:0]  rsp_length_ff, rsp_length_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;

   logic                 is_cr;
   logic                 advance;
   logic                 process;
   hex_digit_type        digit;
   logic [4:0]           count_next;
   logic [5:0]           nibble_shift;
   logic [7:0]           len_next;
   status_type           line_status;

   // A carriage return may only be processed once the result register is
   // free, or is being emptied in this cycle.
   assign is_cr   = (in_byte_ff == CHAR_CR);
   assign advance = !(in_valid_ff && is_cr && rsp_valid_ff && !rsp_chan.ready);
   assign process = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   assign digit      = hex_decode(in_byte_ff);
   assign count_next = digit_count_ff + 5'd1;
   assign len_next   = {len_acc_ff[3:0], digit.value};
   // Byte index times eight, plus four for the high nibble of the byte.
   assign nibble_shift = {digit_count_ff[3:1], ~digit_count_ff[0], 2'b00};

   always_comb begin
      case (phase_ff)
         PH_DONE: line_status = STATUS_OK;
         PH_TYPE: line_status = STATUS_BAD_TYPE;
         PH_ERR:  line_status = error_code_ff;
         default: line_status = STATUS_BAD_HEX;
      endcase
   end

   always_comb begin
      in_valid_in     = in_valid_ff;
      in_byte_in      = in_byte_ff;
      phase_in        = phase_ff;
      digit_count_in  = digit_count_ff;
      id_acc_in       = id_acc_ff;
      len_acc_in      = len_acc_ff;
      payload_acc_in  = payload_acc_ff;
      extended_in     = extended_ff;
      error_code_in   = error_code_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_extended_in = rsp_extended_ff;
      rsp_can_id_in   = rsp_can_id_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_payload_in  = rsp_payload_ff;

      if (process) begin
         in_valid_in = 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.rx_byte;
      end

      if (process) begin
         if (is_cr) begin
            // Emit the line result, then start a fresh line.
            rsp_valid_in  = 1'b1;
            rsp_status_in = line_status;
            if (line_status == STATUS_OK) begin
               rsp_extended_in = extended_ff;
               rsp_can_id_in   = id_acc_ff;
               rsp_length_in   = len_acc_ff[LENGTH_W-1:0];
               rsp_payload_in  = payload_acc_ff;
            end else begin
               rsp_extended_in = 1'b0;
               rsp_can_id_in   = '0;
               rsp_length_in   = '0;
               rsp_payload_in  = '0;
            end
            phase_in       = PH_TYPE;
            digit_count_in = '0;
            id_acc_in      = '0;
            len_acc_in     = '0;
            payload_acc_in = '0;
            extended_in    = 1'b0;
            error_code_in  = STATUS_OK;
         end else begin
            case (phase_ff)
               PH_TYPE: begin
                  digit_count_in = '0;
                  if (in_byte_ff == CHAR_EXT_LO || in_byte_ff == CHAR_EXT_UP) begin
                     extended_in = 1'b1;
                     phase_in    = PH_ID;
                  end else if (in_byte_ff == CHAR_STD_LO
                               || in_byte_ff == CHAR_STD_UP) begin
                     extended_in = 1'b0;
                     phase_in    = PH_ID;
                  end else begin
                     error_code_in = STATUS_BAD_TYPE;
                     phase_in      = PH_ERR;
                  end
               end
               PH_ID: begin
                  if (!digit.valid) begin
                     error_code_in = STATUS_BAD_HEX;
                     phase_in      = PH_ERR;
                  end else begin
                     id_acc_in      = {id_acc_ff[CAN_ID_W-5:0], digit.value};
                     digit_count_in = count_next;
                     if (count_next >= (extended_ff ? EXT_DIGITS : STD_DIGITS)) begin
                        digit_count_in = '0;
                        phase_in       = PH_LEN;
                     end
                  end
               end
               PH_LEN: begin
                  if (!digit.valid) begin
                     error_code_in = STATUS_BAD_HEX;
                     phase_in      = PH_ERR;
                  end else begin
                     len_acc_in     = len_next;
                     digit_count_in = count_next;
                     if (count_next >= LEN_DIGITS) begin
                        digit_count_in = '0;
                        if (len_next > MAX_LEN) begin
                           error_code_in = STATUS_BAD_LEN;
                           phase_in      = PH_ERR;
                        end else if (len_next == 8'd0) begin
                           phase_in = PH_DONE;
                        end else begin
                           phase_in = PH_DATA;
                        end
                     end
                  end
               end
               PH_DATA: begin
                  if (!digit.valid) begin
                     error_code_in = STATUS_BAD_HEX;
                     phase_in      = PH_ERR;
                  end else begin
                     payload_acc_in = payload_acc_ff
                                      | (PAYLOAD_W'(digit.value) << nibble_shift);
                     digit_count_in = count_next;
                     if ({4'd0, count_next} >= {len_acc_ff, 1'b0}) begin
                        phase_in = PH_DONE;
                     end
                  end
               end
               default: begin
                  // Finished or failed line: wait for the carriage return.
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         phase_ff       <= PH_TYPE;
         digit_count_ff <= '0;
         id_acc_ff      <= '0;
         len_acc_ff     <= '0;
         payload_acc_ff <= '0;
         extended_ff    <= 1'b0;
         error_code_ff  <= STATUS_OK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         id_acc_ff      <= id_acc_in;
         len_acc_ff     <= len_acc_in;
         payload_acc_ff <= payload_acc_in;
         extended_ff    <= extended_in;
         error_code_ff  <= error_code_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      in_byte_ff      <= in_byte_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_extended_ff <= rsp_extended_in;
      rsp_can_id_ff   <= rsp_can_id_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_payload_ff  <= rsp_payload_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.extended = rsp_extended_ff;
   assign rsp_chan.can_id   = rsp_can_id_ff;
   assign rsp_chan.length   = rsp_length_ff;
   assign rsp_chan.payload  = rsp_payload_ff;

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the ASCII CAN frame line parser. Characters go in
// one item at a time; every carriage return must come back as one frame item,
// in order, matching a typed directed frame or the bench's own line parser.
module testbench;
   import acfp_pkg::*;

   // Outcome of one text line, laid out like the result channel.
   typedef struct packed {
      status_type            status;
      logic                  extended;
      logic [CAN_ID_W-1:0]   can_id;
      logic [LENGTH_W-1:0]   length;
      logic [PAYLOAD_W-1:0]  payload;
   } frame_type;

   // Where the bench's own line parser stands within the current line.
   typedef enum logic [2:0] {
      LN_TYPE,
      LN_ID,
      LN_LEN,
      LN_DATA,
      LN_DONE,
      LN_SKIP
   } line_phase_type;

   // Ways the result side paces its ready.
   typedef enum logic [1:0] {
      PACE_FULL,
      PACE_COIN,
      PACE_SPARSE,
      PACE_PERIODIC
   } rsp_pace_type;

   typedef logic [RX_BYTE_W-1:0] char_q_type[$];

   // One directed line. The carriage return is appended by the loop. When
   // typed is set, the frame written here is the expected one; otherwise the
   // bench's line parser supplies it.
   typedef struct {
      string      text;
      bit         typed;
      frame_type  want;
   } line_row_type;

   localparam int EXT_DIGITS    = 8;
   localparam int STD_DIGITS    = 3;
   localparam int MAX_BYTES     = 8;
   localparam int RANDOM_CHARS  = 1120;
   localparam int RSP_HOLD      = 300;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 400000;

   localparam frame_type BAD_TYPE_F = '{STATUS_BAD_TYPE, 1'b0, '0, '0, '0};
   localparam frame_type BAD_LEN_F  = '{STATUS_BAD_LEN, 1'b0, '0, '0, '0};
   localparam frame_type BAD_HEX_F  = '{STATUS_BAD_HEX, 1'b0, '0, '0, '0};
   localparam frame_type NO_FRAME   = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   acfp_req_if req_chan ();
   acfp_rsp_if rsp_chan ();

   ascii_can_frame_parser u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Frames the parser owes us, oldest first.
   frame_type expected_frames[$];
   int        mismatch_count = 0;
   int        cycle_count = 0;

   // State of the bench's line parser.
   line_phase_type       line_phase = LN_TYPE;
   int                   digit_idx = 0;
   logic [CAN_ID_W-1:0]  id_acc = '0;
   logic [7:0]           len_acc = '0;
   logic [PAYLOAD_W-1:0] data_acc = '0;
   logic                 is_ext = 1'b0;
   status_type           line_err = STATUS_OK;

   // Sender burst control and the one-shot long hold on the result side.
   int burst_left = 0;
   bit steady_sender = 1'b0;
   bit rsp_hold_request = 1'b0;

   // Directed lines: both empty-line and unknown-type cases, the id and
   // payload extremes, length zero and length just past the limit, a bad
   // digit in each field (with the characters just outside the hex ranges),
   // lines cut short in each field, and junk after a complete payload.
   line_row_type directed_rows[] = '{
      '{"", 1'b1, BAD_TYPE_F},
      '{"Q123", 1'b1, BAD_TYPE_F},
      '{"\377t12300", 1'b1, BAD_TYPE_F},
      '{"xFFFFFFFF08FFFFFFFFFFFFFFFF", 1'b1,
        '{STATUS_OK, 1'b1, 32'hFFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF}},
      '{"t00000", 1'b1, '{STATUS_OK, 1'b0, 32'h0, 4'd0, 64'h0}},
      '{"t12300ZZZ", 1'b1, '{STATUS_OK, 1'b0, 32'h123, 4'd0, 64'h0}},
      '{"t12309", 1'b1, BAD_LEN_F},
      '{"tFFFFF", 1'b1, BAD_LEN_F},
      '{"t12", 1'b1, BAD_HEX_F},
      '{"x0123456", 1'b1, BAD_HEX_F},
      '{"x", 1'b1, BAD_HEX_F},
      '{"t1230", 1'b1, BAD_HEX_F},
      '{"t12301", 1'b1, BAD_HEX_F},
      '{"t1G3", 1'b1, BAD_HEX_F},
      '{"t@00", 1'b1, BAD_HEX_F},
      '{"x`0", 1'b1, BAD_HEX_F},
      '{"Tg", 1'b1, BAD_HEX_F},
      '{"t123:1", 1'b1, BAD_HEX_F},
      '{"t12301/9", 1'b1, BAD_HEX_F},
      '{"T7aB0311aBcD", 1'b0, NO_FRAME},
      '{"X1fE9a0b7020a5Fxyz\377", 1'b0, NO_FRAME},
      '{"t9ab080123456789abcdef", 1'b0, NO_FRAME},
      '{"x0000000008000000000000000001", 1'b0, NO_FRAME}
   };

   // Advances the bench's line parser by one character. On a carriage return
   // it hands back the frame that the line produced and starts a new line.
   task automatic parse_char(input logic [RX_BYTE_W-1:0] c, output bit hit,
                             output frame_type frame);
      logic [3:0] nib;
      bit         is_hex;
      int         shift;
      hit = 1'b0;
      frame = '0;
      is_hex = 1'b1;
      nib = '0;
      if ("0" <= c && c <= "9") begin
         nib = c[3:0];
      end else if (("a" <= c && c <= "f") || ("A" <= c && c <= "F")) begin
         nib = c[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
      end

      if (c == CHAR_CR) begin
         hit = 1'b1;
         case (line_phase)
            LN_DONE: begin
               frame.status = STATUS_OK;
               frame.extended = is_ext;
               frame.can_id = id_acc;
               frame.length = len_acc[3:0];
               frame.payload = data_acc;
            end
            LN_TYPE: frame.status = STATUS_BAD_TYPE;
            LN_SKIP: frame.status = line_err;
            default: frame.status = STATUS_BAD_HEX;
         endcase
         line_phase = LN_TYPE;
         digit_idx = 0;
         id_acc = '0;
         len_acc = '0;
         data_acc = '0;
         is_ext = 1'b0;
         line_err = STATUS_OK;
         return;
      end

      // A bad digit in any field poisons the rest of the line.
      if (!is_hex && line_phase inside {LN_ID, LN_LEN, LN_DATA}) begin
         line_err = STATUS_BAD_HEX;
         line_phase = LN_SKIP;
         return;
      end

      case (line_phase)
         LN_TYPE: begin
            digit_idx = 0;
            if (c == CHAR_EXT_LO || c == CHAR_EXT_UP) begin
               is_ext = 1'b1;
               line_phase = LN_ID;
            end else if (c == CHAR_STD_LO || c == CHAR_STD_UP) begin
               is_ext = 1'b0;
               line_phase = LN_ID;
            end else begin
               line_err = STATUS_BAD_TYPE;
               line_phase = LN_SKIP;
            end
         end
         LN_ID: begin
            id_acc = {id_acc[CAN_ID_W-5:0], nib};
            digit_idx++;
            if (digit_idx >= (is_ext ? EXT_DIGITS : STD_DIGITS)) begin
               digit_idx = 0;
               line_phase = LN_LEN;
            end
         end
         LN_LEN: begin
            len_acc = {len_acc[3:0], nib};
            digit_idx++;
            if (digit_idx >= 2) begin
               digit_idx = 0;
               if (len_acc > MAX_BYTES) begin
                  line_err = STATUS_BAD_LEN;
                  line_phase = LN_SKIP;
               end else begin
                  line_phase = (len_acc == 0) ? LN_DONE : LN_DATA;
               end
            end
         end
         LN_DATA: begin
            // High nibble of each byte comes first.
            shift = ((digit_idx >> 1) & 7) * 8 + (digit_idx[0] ? 0 : 4);
            data_acc |= PAYLOAD_W'(nib) << shift;
            digit_idx++;
            if (digit_idx >= 2 * len_acc) line_phase = LN_DONE;
         end
         default: ;
      endcase
   endtask

   function automatic logic [RX_BYTE_W-1:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 4'd10);
   endfunction

   function automatic logic [RX_BYTE_W-1:0] junk_char();
      logic [RX_BYTE_W-1:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == CHAR_CR) ? 8'h20 : b;
   endfunction

   // Builds one random line. Most lines are well formed with random content,
   // so that payloads of every length get parsed; some carry a length past
   // the limit, some are cut short or have one character overwritten, and
   // the rest are raw noise.
   function automatic void make_line(output char_q_type line);
      int                   pick;
      int                   cut;
      int                   pos;
      logic [RX_BYTE_W-1:0] tc;
      logic [7:0]           lenv;
      bit                   ext;
      line = {};
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
         repeat ($urandom_range(0, 12)) line.push_back(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 3))
            0: tc = CHAR_EXT_LO;
            1: tc = CHAR_EXT_UP;
            2: tc = CHAR_STD_LO;
            default: tc = CHAR_STD_UP;
         endcase
         ext = (tc == CHAR_EXT_LO || tc == CHAR_EXT_UP);
         line.push_back(tc);
         repeat (ext ? EXT_DIGITS : STD_DIGITS) line.push_back(hex_char(4'($urandom)));
         lenv = (pick >= 80) ? 8'($urandom_range(MAX_BYTES + 1, 255))
                             : 8'($urandom_range(0, MAX_BYTES));
         line.push_back(hex_char(lenv[7:4]));
         line.push_back(hex_char(lenv[3:0]));
         if (lenv <= MAX_BYTES) repeat (2 * lenv) line.push_back(hex_char(4'($urandom)));
         if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 4)) line.push_back(junk_char());
         if (pick >= 65 && pick < 80) begin
            if ($urandom_range(0, 1)) begin
               cut = $urandom_range(0, line.size() - 1);
               while (line.size() > cut) void'(line.pop_back());
            end else begin
               pos = $urandom_range(1, line.size() - 1);
               line[pos] = 8'($urandom_range(0, 255));
            end
         end
      end
      line.push_back(CHAR_CR);
   endfunction

   // Offers one character and holds it until the parser takes it. Called at
   // a rising edge. Gaps may come between bursts unless the sender is in
   // a steady stretch. Once the character is taken, the bench's parser runs
   // and any frame it produces (or the typed one, for directed rows) is queued.
   task automatic send_char(input logic [RX_BYTE_W-1:0] c, input bit typed,
                            input frame_type want);
      int        gap;
      bit        hit;
      frame_type guess;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= c;
      do @(posedge clock); while (!req_chan.ready);
      parse_char(c, hit, guess);
      if (hit) expected_frames.push_back(typed ? want : guess);
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch in %s at cycle %0d: got %h, expected %h",
               field, cycle_count, got, want);
      mismatch_count++;
   endtask

   // Stimulus: reset, the directed lines, then random lines. At the start of
   // the random part the result side holds off for a long stretch so that the
   // parser backs up into its input; halfway through, the sender stops until
   // every owed frame has come back.
   initial begin
      char_q_type line;
      int         random_chars;
      bit         paused;
      random_chars = 0;
      paused = 1'b0;
      req_chan.valid <= 1'b0;
      req_chan.rx_byte <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (int i = 0; i < directed_rows[r].text.len(); i++) begin
            send_char(directed_rows[r].text[i], 1'b0, NO_FRAME);
         end
         send_char(CHAR_CR, directed_rows[r].typed, directed_rows[r].want);
      end

      rsp_hold_request = 1'b1;
      while (random_chars < RANDOM_CHARS) begin
         if (!paused && random_chars >= RANDOM_CHARS / 2) begin
            paused = 1'b1;
            req_chan.valid <= 1'b0;
            wait (expected_frames.size() == 0);
            @(posedge clock);
         end
         if ($urandom_range(0, 4) == 0) steady_sender = !steady_sender;
         make_line(line);
         foreach (line[i]) send_char(line[i], 1'b0, NO_FRAME);
         random_chars += line.size();
      end

      req_chan.valid <= 1'b0;
      wait (expected_frames.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Result-side ready. It runs through paces of random length: always
   // ready, a coin toss, mostly stalled, and a fixed one-in-three stall. The
   // long hold is counted down here once it has been requested.
   initial begin
      rsp_pace_type pace;
      int           pace_left;
      int           hold_left;
      int           tick;
      bit           hold_taken;
      pace = PACE_FULL;
      pace_left = 0;
      hold_left = 0;
      tick = 0;
      hold_taken = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (rsp_hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = RSP_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (pace_left == 0) begin
               pace = rsp_pace_type'($urandom_range(0, 3));
               pace_left = $urandom_range(10, 80);
            end
            pace_left--;
            case (pace)
               PACE_FULL:   rsp_chan.ready <= 1'b1;
               PACE_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
               PACE_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_chan.ready <= (tick % 3 != 0);
            endcase
         end
      end
   end

   // Every frame taken from the parser is held against the oldest owed one.
   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_frames.size() == 0) begin
            report_mismatch("unowed frame id", 64'(rsp_chan.can_id), 64'h0);
         end else begin
            want = expected_frames.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", 64'(rsp_chan.status), 64'(want.status));
            if (rsp_chan.extended !== want.extended)
               report_mismatch("extended", 64'(rsp_chan.extended), 64'(want.extended));
            if (rsp_chan.can_id !== want.can_id)
               report_mismatch("can_id", 64'(rsp_chan.can_id), 64'(want.can_id));
            if (rsp_chan.length !== want.length)
               report_mismatch("length", 64'(rsp_chan.length), 64'(want.length));
            if (rsp_chan.payload !== want.payload)
               report_mismatch("payload", rsp_chan.payload, want.payload);
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
